// ----- rtl/core/crct_pkg.sv -----
package crct_pkg;

    // field widths
    localparam int LINE_W      = 32;
    localparam int COUNT_W     = 20;
    localparam int LEN_W       = 16;
    localparam int OP_W        = 2;

    // stream packing
    localparam int IN_FIELDS_W  = LINE_W + COUNT_W + LEN_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = LINE_W + LEN_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // request op codes
    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [LINE_W-1:0] LINE_TOP = '1;

    typedef enum logic [1:0] {
        CMD_ADD,
        CMD_RESTART,
        CMD_CLEAR,
        CMD_NOP
    } t_cmd;

    // decoded request handed from front to back
    typedef struct packed {
        t_cmd              cmd;
        logic [LINE_W-1:0] first;
        logic [LINE_W-1:0] blk_end;
        logic [LEN_W-1:0]  len;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_PLACE,
        ST_ABSORB,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/contiguous_range_completion_tracker_top.sv -----
// channel   dir  handshake                       payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tdata: first_line, line_count, longest_line
//                                                tuser: op
// m_axis    out  m_axis_tvalid / m_axis_tready   tdata: watermark, max_length, table_full
//
// one request a cycle enters the front register while the queue takes it; the back works on one at a time
// restart, clear and unused op: the back goes from idle straight to done, then loads the result register
// add beyond the watermark: the store state reads one table entry per cycle and stops early when
//   the start is already stored; else the place state fills the first free slot or drops the add
// add at or below the watermark: from 1 to AHEAD_DEPTH + 1 passes over the single read port
//   of the ahead table until nothing is absorbed
// synchronous active-low reset empties the table at once; a stalled result
// holds in the output register while the front and queue take further requests
module contiguous_range_completion_tracker_top
    import crct_pkg::*;
#(
    parameter int AHEAD_DEPTH = 16
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // first_line [31:0], line_count [51:32], longest_line [67:52], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op [1:0]
    input  logic [OP_W-1:0]        s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // watermark [31:0], max_length [47:32], table_full [48], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic  w_f_valid;
    logic  w_f_ready;
    t_item w_f_item;
    logic  w_b_valid;
    logic  w_b_ready;
    t_item w_b_item;

    crct_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_q_valid     (w_f_valid),
        .i_q_ready     (w_f_ready),
        .o_q_item      (w_f_item)
    );

    crct_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_push_item  (w_f_item),
        .o_pop_valid  (w_b_valid),
        .i_pop_ready  (w_b_ready),
        .o_pop_item   (w_b_item)
    );

    crct_back #(
        .AHEAD_DEPTH (AHEAD_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_b_valid),
        .o_q_ready     (w_b_ready),
        .i_q_item      (w_b_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- rtl/core/crct_front.sv -----
module crct_front
    import crct_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // first_line, line_count, longest_line, zero pad
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,
    // op
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  o_q_valid,
    input  logic                  i_q_ready,
    output t_item                 o_q_item
);

    logic                 r_valid;
    logic                 n_valid;
    t_item                r_item;
    t_item                n_item;
    logic [LINE_W:0]      w_sum;
    logic [LINE_W-1:0]    w_first;
    logic [COUNT_W-1:0]   w_count;
    logic                 w_accept;

    assign s_axis_tready = !r_valid || i_q_ready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_first       = s_axis_tdata[LINE_W-1:0];
    assign w_count       = s_axis_tdata[LINE_W+COUNT_W-1:LINE_W];
    assign w_sum         = {1'b0, w_first} + {{(LINE_W+1-COUNT_W){1'b0}}, w_count};

    // decode op and saturate block end
    always_comb begin
        n_item       = r_item;
        n_valid      = r_valid && !i_q_ready;
        if (w_accept) begin
            n_valid       = 1'b1;
            n_item.first  = w_first;
            n_item.len    = s_axis_tdata[IN_FIELDS_W-1:LINE_W+COUNT_W];
            n_item.blk_end = w_sum[LINE_W] ? LINE_TOP : w_sum[LINE_W-1:0];
            unique case (s_axis_tuser)
                OP_ADD:     n_item.cmd = CMD_ADD;
                OP_RESTART: n_item.cmd = CMD_RESTART;
                OP_CLEAR:   n_item.cmd = CMD_CLEAR;
                default:    n_item.cmd = CMD_NOP;
            endcase
        end
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

    assign o_q_valid = r_valid;
    assign o_q_item  = r_item;

endmodule

// ----- rtl/core/crct_queue.sv -----
module crct_queue
    import crct_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    t_item       r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push;
    logic        w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_slot[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            if (w_push && !w_pop)      r_count <= r_count + 2'd1;
            else if (w_pop && !w_push) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_slot[r_wr_ptr] <= i_push_item;
    end

endmodule

// ----- rtl/core/crct_back.sv -----
module crct_back
    import crct_pkg::*;
#(
    parameter int AHEAD_DEPTH = 16
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    output logic                   o_q_ready,
    input  t_item                  i_q_item,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // watermark, max_length, table_full, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int IDX_W = (AHEAD_DEPTH > 1) ? $clog2(AHEAD_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(AHEAD_DEPTH - 1);

    // ahead table: start and end in memory, valid bits in flops
    logic [LINE_W-1:0]      mem_start [AHEAD_DEPTH];
    logic [LINE_W-1:0]      mem_end   [AHEAD_DEPTH];
    logic                   w_we;
    logic [IDX_W-1:0]       w_waddr;
    logic [LINE_W-1:0]      w_wstart;
    logic [LINE_W-1:0]      w_wend;
    logic [LINE_W-1:0]      r_rd_start;
    logic [LINE_W-1:0]      r_rd_end;

    t_state                 r_state,   n_state;
    t_item                  r_cur,     n_cur;
    logic [LINE_W-1:0]      r_mark,    n_mark;
    logic [LEN_W-1:0]       r_longest, n_longest;
    logic [AHEAD_DEPTH-1:0] r_valid,   n_valid;
    logic [IDX_W-1:0]       r_idx,     n_idx;
    logic                   r_issue,   n_issue;
    logic                   r_chk,     n_chk;
    logic [IDX_W-1:0]       r_chk_idx, n_chk_idx;
    logic                   r_free_ok, n_free_ok;
    logic [IDX_W-1:0]       r_free_idx, n_free_idx;
    logic                   r_changed, n_changed;
    logic                   r_dropped, n_dropped;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    // next state and datapath
    always_comb begin
        logic hit;
        hit         = 1'b0;
        n_state     = r_state;
        n_cur       = r_cur;
        n_mark      = r_mark;
        n_longest   = r_longest;
        n_valid     = r_valid;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_chk       = 1'b0;
        n_chk_idx   = r_idx;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_changed   = r_changed;
        n_dropped   = r_dropped;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        o_q_ready   = 1'b0;
        w_we        = 1'b0;
        w_waddr     = r_chk_idx;
        w_wstart    = r_cur.first;
        w_wend      = r_cur.blk_end;

        // read address issue, one table entry a cycle
        if ((r_state == ST_STORE || r_state == ST_ABSORB) && r_issue) begin
            n_chk   = 1'b1;
            n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);
            n_issue = (r_idx != LAST_IDX);
        end

        unique case (r_state)
            ST_IDLE: begin
                o_q_ready = 1'b1;
                n_dropped = 1'b0;
                n_idx     = '0;
                n_issue   = 1'b1;
                n_free_ok = 1'b0;
                n_changed = 1'b0;
                if (i_q_valid) begin
                    n_cur = i_q_item;
                    unique case (i_q_item.cmd)
                        CMD_ADD: begin
                            if (i_q_item.len > r_longest) n_longest = i_q_item.len;
                            if (i_q_item.first > r_mark) begin
                                n_state = ST_STORE;
                            end else begin
                                if (i_q_item.blk_end > r_mark) n_mark = i_q_item.blk_end;
                                n_state = ST_ABSORB;
                            end
                        end
                        CMD_RESTART: begin
                            n_mark  = i_q_item.first;
                            n_valid = '0;
                            n_state = ST_DONE;
                        end
                        CMD_CLEAR: begin
                            n_mark    = '0;
                            n_longest = '0;
                            n_valid   = '0;
                            n_state   = ST_DONE;
                        end
                        CMD_NOP: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_STORE: begin
                if (r_chk) begin
                    if (r_valid[r_chk_idx] && r_rd_start == r_cur.first) begin
                        // start already stored: keep the larger end
                        w_we    = (r_cur.blk_end > r_rd_end);
                        n_state = ST_DONE;
                    end else begin
                        if (!r_valid[r_chk_idx] && !r_free_ok) begin
                            n_free_ok  = 1'b1;
                            n_free_idx = r_chk_idx;
                        end
                        if (r_chk_idx == LAST_IDX) n_state = ST_PLACE;
                    end
                end
            end
            ST_PLACE: begin
                // new entry in the first free slot, else drop
                if (r_free_ok) begin
                    w_we               = 1'b1;
                    w_waddr            = r_free_idx;
                    n_valid[r_free_idx] = 1'b1;
                end else begin
                    n_dropped = 1'b1;
                end
                n_state = ST_DONE;
            end
            ST_ABSORB: begin
                if (r_chk) begin
                    if (r_valid[r_chk_idx] && r_rd_start <= r_mark) begin
                        hit                = 1'b1;
                        n_valid[r_chk_idx] = 1'b0;
                        n_changed          = 1'b1;
                        if (r_rd_end > r_mark) n_mark = r_rd_end;
                    end
                    // another pass while the last one absorbed anything
                    if (r_chk_idx == LAST_IDX) begin
                        if (r_changed || hit) begin
                            n_idx     = '0;
                            n_issue   = 1'b1;
                            n_changed = 1'b0;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{OUT_PAD_W{1'b0}}, r_dropped, r_longest, r_mark};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mark      <= '0;
            r_longest   <= '0;
            r_valid     <= '0;
            r_issue     <= 1'b0;
            r_chk       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mark      <= n_mark;
            r_longest   <= n_longest;
            r_valid     <= n_valid;
            r_issue     <= n_issue;
            r_chk       <= n_chk;
            r_out_valid <= n_out_valid;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_cur      <= n_cur;
        r_idx      <= n_idx;
        r_chk_idx  <= n_chk_idx;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_changed  <= n_changed;
        r_dropped  <= n_dropped;
        r_out_data <= n_out_data;
    end

    // table memory, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_start[w_waddr] <= w_wstart;
            mem_end[w_waddr]   <= w_wend;
        end
        r_rd_start <= mem_start[r_idx];
        r_rd_end   <= mem_end[r_idx];
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/core/crct_checker.sv -----
module crct_checker
    import crct_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic              w_s_acc;
    logic              w_m_acc;
    logic [3:0]        r_pending;
    logic              r_seen;
    logic [LINE_W-1:0] r_last_mark;
    logic [LEN_W-1:0]  r_last_len;

    assign w_s_acc = s_axis_tvalid && s_axis_tready;
    assign w_m_acc = m_axis_tvalid && m_axis_tready;

    // requests in flight and the previous result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_seen    <= 1'b0;
        end else begin
            if (w_s_acc && !w_m_acc)      r_pending <= r_pending + 4'd1;
            else if (w_m_acc && !w_s_acc) r_pending <= r_pending - 4'd1;
            if (w_m_acc) r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_m_acc) begin
            r_last_mark <= m_axis_tdata[LINE_W-1:0];
            r_last_len  <= m_axis_tdata[LINE_W+LEN_W-1:LINE_W];
        end
    end

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one result per request, never ahead of it, bounded backlog
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_m_acc || r_pending != 4'd0) && r_pending <= 4'd5)
        else $error("result without a pending request or backlog overrun");

    // a dropped add leaves the watermark and does not lower the maximum
    a_drop_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_m_acc && r_seen && m_axis_tdata[LINE_W+LEN_W] |->
        m_axis_tdata[LINE_W-1:0] == r_last_mark &&
        m_axis_tdata[LINE_W+LEN_W-1:LINE_W] >= r_last_len)
        else $error("dropped add moved the watermark");

endmodule

bind contiguous_range_completion_tracker_top crct_checker u_crct_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- dv/tb_contiguous_range_completion_tracker_top.sv -----
`timescale 1ns / 1ps

module tb_contiguous_range_completion_tracker_top;
    import crct_pkg::*;

    localparam int AHEAD_DEPTH = 16;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ITEM_GOAL   = 730;
    localparam int SETTLE      = 320;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // one progress report, laid out as in m_axis_tdata
    typedef struct packed {
        logic              table_full;
        logic [LEN_W-1:0]  max_length;
        logic [LINE_W-1:0] watermark;
    } t_progress;

    typedef struct {
        bit [LINE_W-1:0]  first;
        bit [COUNT_W-1:0] count;
    } t_block;

    // tracks the watermark, the running maximum and the ahead table
    class progress_board;
        bit [LINE_W-1:0] mark;
        bit [LEN_W-1:0]  widest;
        bit              slot_used [AHEAD_DEPTH];
        bit [LINE_W-1:0] slot_lo [AHEAD_DEPTH];
        bit [LINE_W-1:0] slot_hi [AHEAD_DEPTH];
        t_progress       due_progress [$];
        int              faults;

        function new();
            mark   = '0;
            widest = '0;
            faults = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        // fold one accepted request into the tracked state
        function void note_request(logic [OP_W-1:0] op, bit [LINE_W-1:0] first,
                                   bit [COUNT_W-1:0] count, bit [LEN_W-1:0] len);
            bit [LINE_W:0]   sum;
            bit [LINE_W-1:0] blk_end;
            bit [LINE_W-1:0] reach;
            bit              dropped;
            bit              hit;
            bit              grew;
            int              free_slot;
            t_progress       p;
            dropped = 1'b0;
            case (op)
                OP_ADD: begin
                    sum     = {1'b0, first} + (LINE_W + 1)'(count);
                    blk_end = sum[LINE_W] ? LINE_TOP : sum[LINE_W-1:0];
                    if (len > widest) widest = len;
                    if (first > mark) begin
                        // park the block ahead of the watermark
                        hit       = 1'b0;
                        free_slot = -1;
                        for (int i = 0; i < AHEAD_DEPTH; i++) begin
                            if (!hit) begin
                                if (slot_used[i] && slot_lo[i] == first) begin
                                    if (blk_end > slot_hi[i]) slot_hi[i] = blk_end;
                                    hit = 1'b1;
                                end else if (!slot_used[i] && free_slot < 0) begin
                                    free_slot = i;
                                end
                            end
                        end
                        if (!hit) begin
                            if (free_slot < 0) begin
                                dropped = 1'b1;
                            end else begin
                                slot_used[free_slot] = 1'b1;
                                slot_lo[free_slot]   = first;
                                slot_hi[free_slot]   = blk_end;
                            end
                        end
                    end else begin
                        // raise the watermark and swallow reachable entries
                        reach = (blk_end > mark) ? blk_end : mark;
                        do begin
                            grew = 1'b0;
                            for (int i = 0; i < AHEAD_DEPTH; i++) begin
                                if (slot_used[i] && slot_lo[i] <= reach) begin
                                    if (slot_hi[i] > reach) reach = slot_hi[i];
                                    slot_used[i] = 1'b0;
                                    grew = 1'b1;
                                end
                            end
                        end while (grew);
                        mark = reach;
                    end
                end
                OP_RESTART: begin
                    mark = first;
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
                end
                OP_CLEAR: begin
                    mark   = '0;
                    widest = '0;
                    foreach (slot_used[i]) slot_used[i] = 1'b0;
                end
                default: begin
                end
            endcase
            p.watermark  = mark;
            p.max_length = widest;
            p.table_full = dropped;
            due_progress.push_back(p);
        endfunction

        // compare one delivered report with the oldest one due
        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            t_progress got;
            t_progress want;
            got = t_progress'(tdata[OUT_FIELDS_W-1:0]);
            if (due_progress.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: unexpected report wm=%h len=%h full=%b", $realtime,
                             got.watermark, got.max_length, got.table_full);
                return;
            end
            want = due_progress.pop_front();
            if (got.watermark !== want.watermark || got.max_length !== want.max_length ||
                got.table_full !== want.table_full) begin
                faults++;
                if (faults <= 10)
                    $display("%0t: mismatch wm=%h/%h len=%h/%h full=%b/%b (exp/act)",
                             $realtime, want.watermark, got.watermark, want.max_length,
                             got.max_length, want.table_full, got.table_full);
            end
        endfunction

        function int outstanding();
            return due_progress.size();
        endfunction

        function bit clean();
            return faults == 0 && due_progress.size() == 0;
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // first_line, line_count, longest_line, zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // op
    logic [OP_W-1:0]        s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // watermark, max_length, table_full, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    progress_board board;
    int            sent_items = 0;
    int            cycles = 0;
    bit            steady = 1'b0;

    contiguous_range_completion_tracker_top #(
        .AHEAD_DEPTH(AHEAD_DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(0, 99) >= 11);
    end

    // note accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            board.note_request(s_axis_tuser, s_axis_tdata[LINE_W-1:0],
                               s_axis_tdata[LINE_W+COUNT_W-1:LINE_W],
                               s_axis_tdata[IN_FIELDS_W-1:LINE_W+COUNT_W]);
    end

    // check delivered reports
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata);
    end

    // present one request and hold it until taken
    task automatic send_request(logic [OP_W-1:0] op, bit [LINE_W-1:0] first,
                                bit [COUNT_W-1:0] count, bit [LEN_W-1:0] len);
        int gap;
        if (!steady && $urandom_range(0, 99) < 11) begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'({len, count, first});
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        if (op != OP_UNUSED) sent_items++;
    endtask

    function automatic bit [COUNT_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return COUNT_W'($urandom());
        return COUNT_W'($urandom_range(1, 3000));
    endfunction

    // extremes, saturation, duplicate starts, a full table and a long absorb chain
    task automatic directed_part();
        send_request(OP_ADD, '0, '1, '1);
        send_request(OP_ADD, '0, '0, '0);
        send_request(OP_UNUSED, '1, '1, '1);
        send_request(OP_RESTART, LINE_TOP - 5, '0, '0);
        send_request(OP_ADD, LINE_TOP - 5, '1, 16'd1);
        send_request(OP_ADD, LINE_TOP, 20'd3, 16'd2);
        send_request(OP_CLEAR, '1, '1, '1);
        send_request(OP_RESTART, 32'd1000, '0, '0);
        // descending starts so the absorb needs many passes
        for (int i = AHEAD_DEPTH - 1; i >= 0; i--)
            send_request(OP_ADD, 32'd1010 + 32'(10 * i), 20'd10, 16'(i));
        send_request(OP_ADD, 32'd2000, 20'd5, 16'h0100);
        send_request(OP_ADD, 32'd1010, 20'd30, '0);
        send_request(OP_ADD, 32'd1020, 20'd1, '0);
        send_request(OP_ADD, 32'd1000, 20'd10, 16'h8000);
    endtask

    // a contiguous run of blocks delivered out of order, with some noise
    task automatic run_episode();
        t_block          blocks [$];
        t_block          blk;
        t_block          tmp;
        bit [LINE_W-1:0] base;
        bit [LINE_W-1:0] cursor;
        bit [LINE_W:0]   sum;
        int              n;
        int              k;
        case ($urandom_range(0, 3))
            0: base = LINE_TOP - LINE_W'($urandom_range(0, 20000));
            1: base = LINE_W'($urandom_range(0, 5000));
            default: base = $urandom();
        endcase
        if ($urandom_range(0, 4) == 0) begin
            base = '0;
            send_request(OP_CLEAR, $urandom(), pick_count(), LEN_W'($urandom()));
        end else begin
            send_request(OP_RESTART, base, pick_count(), LEN_W'($urandom()));
        end
        n = $urandom_range(1, 20);
        cursor = base;
        for (int j = 0; j < n; j++) begin
            blk.first = cursor;
            blk.count = pick_count();
            sum       = {1'b0, cursor} + (LINE_W + 1)'(blk.count);
            cursor    = sum[LINE_W] ? LINE_TOP : sum[LINE_W-1:0];
            blocks.push_back(blk);
        end
        for (int j = n - 1; j > 0; j--) begin
            k         = $urandom_range(0, j);
            tmp       = blocks[j];
            blocks[j] = blocks[k];
            blocks[k] = tmp;
        end
        foreach (blocks[j]) begin
            send_request(OP_ADD, blocks[j].first, blocks[j].count, LEN_W'($urandom()));
            if ($urandom_range(0, 9) == 0)
                send_request(OP_ADD, blocks[j].first, pick_count(), LEN_W'($urandom()));
            if ($urandom_range(0, 11) == 0)
                send_request(OP_W'($urandom_range(0, 3)),
                             ($urandom_range(0, 1) != 0) ? $urandom()
                                 : base + LINE_W'($urandom_range(0, 20000)),
                             pick_count(), LEN_W'($urandom()));
        end
    endtask

    // main sequence
    initial begin
        board         = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_ADD;
        m_axis_tready = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_part();
        while (sent_items < ITEM_GOAL) begin
            steady = (sent_items >= 300 && sent_items < 420);
            run_episode();
        end
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (board.clean())
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- contiguous_range_completion_tracker_top.f -----
rtl/core/crct_pkg.sv
rtl/core/crct_front.sv
rtl/core/crct_queue.sv
rtl/core/crct_back.sv
rtl/core/contiguous_range_completion_tracker_top.sv
rtl/core/crct_checker.sv
dv/tb_contiguous_range_completion_tracker_top.sv
